/* rtl/pfa_pkg.sv */
// shared types and constants for the page frame allocator
package pfa_pkg;

   // default sizes
   localparam int NUM_PAGES_DEF = 1024;
   localparam int REF_WIDTH_DEF = 8;

   // fixed field widths
   localparam int PAGE_W   = 10;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;
   localparam int FREE_W   = 11;

   localparam logic [FREE_W-1:0] FREE_MAX = 11'd2047;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD_PAGE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INCREMENT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DECREMENT = 3'd4;
   localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STS_SATURATED = 2'd3;

   // request transaction
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [PAGE_W-1:0] page;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   alloc_page;
      logic                alloc_valid;
      logic [COUNT_W-1:0]  ref_count;
      logic [FREE_W-1:0]   free_pages;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic clear_wr;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

/* rtl/pfa_datapath.sv */
// datapath of the page frame allocator: count and link memories, list head, free total
module pfa_datapath #(
   parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
   parameter int REF_WIDTH = pfa_pkg::REF_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pfa_pkg::ctl_cmd_type        ctl,
   output pfa_pkg::dp_status_type      dp_status,
   input  pfa_pkg::req_type            req_data,
   input  logic                        csr_wr_en,
   input  logic [pfa_pkg::PAGE_W-1:0]  csr_wr_data,
   output logic                        rsp_valid,
   output pfa_pkg::rsp_type            rsp_data
);

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam logic [REF_WIDTH-1:0] REF_ONE = REF_WIDTH'(1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

   // memories
   logic [REF_WIDTH-1:0]       refs_mem [NUM_PAGES];
   logic [pfa_pkg::PAGE_W-1:0] link_mem [NUM_PAGES];

   // registers
   logic [pfa_pkg::PAGE_W-1:0] first_usable_ff, first_usable_in;
   logic [pfa_pkg::CMD_W-1:0]  cmd_ff;
   logic [pfa_pkg::PAGE_W-1:0] page_ff;
   logic                       oor_ff;
   logic [REF_WIDTH-1:0]       refs_rd_ff;
   logic [pfa_pkg::PAGE_W-1:0] link_rd_ff;
   logic [pfa_pkg::PAGE_W-1:0] head_ff, head_in;
   logic [pfa_pkg::FREE_W-1:0] free_ff, free_in;
   logic [IDX_W-1:0]           clr_addr_ff, clr_addr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   pfa_pkg::rsp_type           rsp_ff, rsp_in;

   // update signals
   logic                 ref_we;
   logic [IDX_W-1:0]     ref_waddr;
   logic [REF_WIDTH-1:0] ref_wdata;
   logic                 push;
   logic [REF_WIDTH-1:0] new_ref;
   logic                 req_oor;

   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] page_idx;
   logic [IDX_W-1:0] head_idx;

   assign req_idx  = IDX_W'(req_data.page);
   assign page_idx = IDX_W'(page_ff);
   assign head_idx = IDX_W'(head_ff);

   // range check at acceptance
   assign req_oor = (req_data.page < first_usable_ff) ||
                    (32'(req_data.page) >= 32'(NUM_PAGES));

   // configuration register
   assign first_usable_in = csr_wr_en ? csr_wr_data : first_usable_ff;

   // capture the request
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff  <= req_data.command;
         page_ff <= req_data.page;
         oor_ff  <= req_oor;
      end
   end

   // count memory: clearing pass, update write, read at acceptance
   always_ff @(posedge clock) begin
      if (ctl.clear_wr) begin
         refs_mem[clr_addr_ff] <= '0;
      end else if (ref_we) begin
         refs_mem[ref_waddr] <= ref_wdata;
      end
      if (ctl.accept) begin
         refs_rd_ff <= refs_mem[req_idx];
      end
   end

   // link memory: written on push, head link read at acceptance
   always_ff @(posedge clock) begin
      if (ctl.exec && push) begin
         link_mem[page_idx] <= head_ff;
      end
      if (ctl.accept) begin
         link_rd_ff <= link_mem[head_idx];
      end
   end

   // execute one transaction
   always_comb begin
      ref_we    = 1'b0;
      ref_waddr = page_idx;
      ref_wdata = refs_rd_ff;
      push      = 1'b0;
      new_ref   = refs_rd_ff;
      head_in   = head_ff;
      free_in   = free_ff;
      rsp_in    = '0;
      rsp_in.status = pfa_pkg::STS_OK;

      if (cmd_ff == pfa_pkg::CMD_ALLOC) begin
         // pop the head of the free list
         if (free_ff != '0) begin
            ref_we             = 1'b1;
            ref_waddr          = head_idx;
            ref_wdata          = REF_ONE;
            head_in            = link_rd_ff;
            free_in            = free_ff - 1'b1;
            rsp_in.alloc_page  = head_ff;
            rsp_in.alloc_valid = 1'b1;
            rsp_in.ref_count   = pfa_pkg::COUNT_W'(REF_ONE);
         end else begin
            rsp_in.status = pfa_pkg::STS_EMPTY;
         end
      end else if (oor_ff) begin
         rsp_in.status = pfa_pkg::STS_RANGE;
      end else begin
         unique case (cmd_ff)
            pfa_pkg::CMD_ADD_PAGE: begin
               new_ref = '0;
               push    = 1'b1;
            end
            pfa_pkg::CMD_FREE: begin
               if (refs_rd_ff != '0) begin
                  new_ref = refs_rd_ff - 1'b1;
               end
               push = (new_ref == '0);
            end
            pfa_pkg::CMD_INCREMENT: begin
               if (&refs_rd_ff) begin
                  rsp_in.status = pfa_pkg::STS_SATURATED;
               end else begin
                  new_ref = refs_rd_ff + 1'b1;
               end
            end
            pfa_pkg::CMD_DECREMENT: begin
               if (refs_rd_ff == '0) begin
                  rsp_in.status = pfa_pkg::STS_SATURATED;
               end else begin
                  new_ref = refs_rd_ff - 1'b1;
               end
            end
            default: begin
               // query and unused codes leave the count alone
               new_ref = refs_rd_ff;
            end
         endcase
         ref_we           = 1'b1;
         ref_wdata        = new_ref;
         rsp_in.ref_count = pfa_pkg::COUNT_W'(new_ref);
         // push onto the free list, total saturates
         if (push) begin
            head_in = page_ff;
            if (free_ff != pfa_pkg::FREE_MAX) begin
               free_in = free_ff + 1'b1;
            end
         end
      end
      rsp_in.free_pages = free_in;
      if (!ctl.exec) begin
         ref_we  = 1'b0;
         head_in = head_ff;
         free_in = free_ff;
      end
   end

   // response strobe lasts one cycle
   assign rsp_valid_in = ctl.exec;

   // clearing pass address
   assign clr_addr_in = ctl.clear_wr ? (clr_addr_ff + 1'b1) : clr_addr_ff;
   assign dp_status.clear_last = (clr_addr_ff == LAST_IDX);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_usable_ff <= '0;
         head_ff         <= '0;
         free_ff         <= '0;
         clr_addr_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         first_usable_ff <= first_usable_in;
         head_ff         <= head_in;
         free_ff         <= free_in;
         clr_addr_ff     <= clr_addr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/pfa_ctrl.sv */
// controller state machine of the page frame allocator
module pfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pfa_pkg::dp_status_type dp_status,
   output pfa_pkg::ctl_cmd_type   ctl
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register, reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   assign busy         = (state_ff != ST_IDLE);
   assign ctl.accept   = start && (state_ff == ST_IDLE);
   assign ctl.exec     = (state_ff == ST_EXEC);
   assign ctl.clear_wr = (state_ff == ST_CLEAR);

endmodule

/* rtl/page_frame_allocator_refcount.sv */
// top level of the page frame allocator with reference counts
// A transaction is accepted when start is high and busy is low. The acceptance
// cycle reads the count memory and the link memory at the list head, the next
// cycle (busy high) writes the count memory, writes the link memory on a push and
// updates the list head and free total. The response appears on rsp_data with
// rsp_valid high for exactly one cycle, the cycle after the update; it cannot be
// stalled and must be taken then. A new transaction may be accepted in that same
// cycle, but not while the previous one is being executed. After reset busy
// stays high while the count memory is swept to zero; csr writes are taken at
// any time but should be made only while idle.
module page_frame_allocator_refcount #(
   parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
   parameter int REF_WIDTH = pfa_pkg::REF_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  pfa_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output pfa_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [pfa_pkg::PAGE_W-1:0] csr_wr_data
);

   pfa_pkg::ctl_cmd_type   ctl;
   pfa_pkg::dp_status_type dp_status;

   // sequencing
   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .ctl       (ctl)
   );

   // memories and list state
   pfa_datapath #(
      .NUM_PAGES (NUM_PAGES),
      .REF_WIDTH (REF_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .dp_status   (dp_status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

/* tb/page_frame_allocator_refcount_tb.sv */
// testbench for the page frame allocator with reference counts
module page_frame_allocator_refcount_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PAGES   = pfa_pkg::NUM_PAGES_DEF;
   localparam int REF_MAX     = (1 << pfa_pkg::REF_WIDTH_DEF) - 1;
   localparam int STALL_LIMIT = 4000;
   localparam int PAGE_W      = pfa_pkg::PAGE_W;
   localparam int CMD_W       = pfa_pkg::CMD_W;
   localparam int COUNT_W     = pfa_pkg::COUNT_W;
   localparam int FREE_W      = pfa_pkg::FREE_W;
   localparam int REQ_W       = $bits(pfa_pkg::req_type);

   // unused command codes, treated as query
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   pfa_pkg::req_type     req_data;
   logic                 rsp_valid;
   pfa_pkg::rsp_type     rsp_data;
   logic                 csr_wr_en;
   logic [PAGE_W-1:0]    csr_wr_data;

   // local copy of the allocator state
   logic [COUNT_W-1:0] frame_refs [NUM_PAGES];
   logic [PAGE_W-1:0]  frame_link [NUM_PAGES];
   bit                 link_written [NUM_PAGES];
   logic [PAGE_W-1:0]  list_top;
   bit                 list_filled;
   logic [FREE_W-1:0]  free_count;
   logic [PAGE_W-1:0]  low_page;

   pfa_pkg::rsp_type pending_rsps [$];
   int               mismatches;
   int               stall_cycles;
   bit               gaps_on;

   page_frame_allocator_refcount #(
      .NUM_PAGES(NUM_PAGES),
      .REF_WIDTH(pfa_pkg::REF_WIDTH_DEF)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // push a page on the free list
   function automatic void push_frame(logic [PAGE_W-1:0] pg);
      frame_link[pg] = list_top;
      link_written[pg] = 1'b1;
      list_top = pg;
      if (free_count != pfa_pkg::FREE_MAX) free_count++;
      list_filled = 1'b1;
   endfunction

   // apply one transaction to the local state and return the expected response
   function automatic pfa_pkg::rsp_type page_op(pfa_pkg::req_type r);
      pfa_pkg::rsp_type   e;
      logic [COUNT_W-1:0] c;
      e = '0;
      if (r.command == pfa_pkg::CMD_ALLOC) begin
         if (list_filled && free_count != 0) begin
            frame_refs[list_top] = COUNT_W'(1);
            e.alloc_page = list_top;
            e.alloc_valid = 1'b1;
            e.ref_count = COUNT_W'(1);
            list_top = frame_link[list_top];
            free_count--;
            list_filled = (free_count != 0);
         end else begin
            e.status = pfa_pkg::STS_EMPTY;
         end
      end else if (r.page < low_page) begin
         e.status = pfa_pkg::STS_RANGE;
      end else begin
         c = frame_refs[r.page];
         case (r.command)
            pfa_pkg::CMD_ADD_PAGE: begin
               c = '0;
               push_frame(r.page);
            end
            pfa_pkg::CMD_FREE: begin
               if (c != 0) c--;
               if (c == 0) push_frame(r.page);
            end
            pfa_pkg::CMD_INCREMENT: begin
               if (c == REF_MAX) e.status = pfa_pkg::STS_SATURATED;
               else c++;
            end
            pfa_pkg::CMD_DECREMENT: begin
               if (c == 0) e.status = pfa_pkg::STS_SATURATED;
               else c--;
            end
            default: ;
         endcase
         frame_refs[r.page] = c;
         e.ref_count = c;
      end
      e.free_pages = free_count;
      return e;
   endfunction

   function automatic string rsp_text(pfa_pkg::rsp_type r);
      return $sformatf("status %0d page %0d valid %0d count %0d free %0d",
                       r.status, r.alloc_page, r.alloc_valid, r.ref_count, r.free_pages);
   endfunction

   // send one transaction, with an occasional gap before it
   task automatic send_page_op(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] page);
      pfa_pkg::req_type r;
      r.command = cmd;
      r.page = page;
      // never pop through a link that was never written
      if (cmd == pfa_pkg::CMD_ALLOC && list_filled && free_count != 0 &&
          !link_written[list_top])
         r.command = pfa_pkg::CMD_QUERY;
      if (gaps_on && $urandom_range(99) < 11) begin
         start <= 1'b0;
         req_data <= REQ_W'($urandom());
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      pending_rsps.push_back(page_op(r));
   endtask

   // hold off until every expected response is in
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_first_usable(input logic [PAGE_W-1:0] v);
      wait_for_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      low_page = v;
      @(posedge clock);
   endtask

   // empty list, out of range pages, double free, unused commands
   task automatic test_directed_cases();
      set_first_usable('0);
      send_page_op(pfa_pkg::CMD_ALLOC, 10'd0);
      send_page_op(pfa_pkg::CMD_QUERY, 10'd0);
      send_page_op(pfa_pkg::CMD_QUERY, 10'd1023);
      set_first_usable(10'd10);
      send_page_op(pfa_pkg::CMD_QUERY, 10'd9);
      send_page_op(pfa_pkg::CMD_ADD_PAGE, 10'd9);
      send_page_op(pfa_pkg::CMD_FREE, 10'd0);
      send_page_op(pfa_pkg::CMD_INCREMENT, 10'd5);
      send_page_op(pfa_pkg::CMD_DECREMENT, 10'd9);
      send_page_op(pfa_pkg::CMD_ADD_PAGE, 10'd10);
      send_page_op(pfa_pkg::CMD_QUERY, 10'd10);
      send_page_op(pfa_pkg::CMD_ALLOC, 10'd1023);
      send_page_op(pfa_pkg::CMD_ALLOC, 10'd0);
      send_page_op(pfa_pkg::CMD_INCREMENT, 10'd10);
      send_page_op(pfa_pkg::CMD_FREE, 10'd10);
      send_page_op(pfa_pkg::CMD_FREE, 10'd10);
      send_page_op(pfa_pkg::CMD_FREE, 10'd10);
      send_page_op(pfa_pkg::CMD_ALLOC, 10'd0);
      send_page_op(pfa_pkg::CMD_ALLOC, 10'd0);
      send_page_op(pfa_pkg::CMD_ALLOC, 10'd0);
      send_page_op(pfa_pkg::CMD_DECREMENT, 10'd20);
      send_page_op(pfa_pkg::CMD_INCREMENT, 10'd1023);
      send_page_op(CMD_SPARE_LO, 10'd1023);
      send_page_op(CMD_SPARE_HI, 10'd1023);
      send_page_op(pfa_pkg::CMD_ADD_PAGE, 10'd1023);
   endtask

   // count saturation, underflow and free at zero count
   task automatic test_count_limits();
      send_page_op(pfa_pkg::CMD_ADD_PAGE, 10'd700);
      repeat (REF_MAX + 1) send_page_op(pfa_pkg::CMD_INCREMENT, 10'd700);
      repeat (REF_MAX + 1) send_page_op(pfa_pkg::CMD_DECREMENT, 10'd700);
      send_page_op(pfa_pkg::CMD_FREE, 10'd700);
      send_page_op(pfa_pkg::CMD_ALLOC, 10'd0);
   endtask

   // random traffic over a few hot pages, some noise over the whole range
   task automatic run_random_phase(input int items, input logic [PAGE_W-1:0] low);
      logic [PAGE_W-1:0] hot [8];
      int                pick;
      logic [CMD_W-1:0]  cmd;
      logic [PAGE_W-1:0] page;
      set_first_usable(low);
      foreach (hot[i]) hot[i] = PAGE_W'($urandom_range(NUM_PAGES - 1, int'(low)));
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(99);
         if (pick < 15) cmd = pfa_pkg::CMD_ADD_PAGE;
         else if (pick < 35) cmd = pfa_pkg::CMD_FREE;
         else if (pick < 55) cmd = pfa_pkg::CMD_ALLOC;
         else if (pick < 75) cmd = pfa_pkg::CMD_INCREMENT;
         else if (pick < 87) cmd = pfa_pkg::CMD_DECREMENT;
         else if (pick < 96) cmd = pfa_pkg::CMD_QUERY;
         else cmd = CMD_W'($urandom_range(int'(CMD_SPARE_HI), int'(CMD_SPARE_LO)));
         if ($urandom_range(9) == 0) page = PAGE_W'($urandom_range(NUM_PAGES - 1));
         else page = hot[$urandom_range(7)];
         send_page_op(cmd, page);
         // now and then let the pipeline run dry
         if ($urandom_range(149) == 0) wait_for_results();
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(400, '0);
      run_random_phase(200, PAGE_W'(NUM_PAGES - 1));
      // long stretch with back to back transactions
      gaps_on = 1'b0;
      run_random_phase(400, PAGE_W'($urandom_range(1022, 1)));
      gaps_on = 1'b1;
      run_random_phase(360, PAGE_W'($urandom_range(200)));
   endtask

   // response checker
   always @(negedge clock) begin : check_rsp
      pfa_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: %s", rsp_text(rsp_data));
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.status !== want.status || rsp_data.alloc_page !== want.alloc_page ||
                rsp_data.alloc_valid !== want.alloc_valid ||
                rsp_data.ref_count !== want.ref_count ||
                rsp_data.free_pages !== want.free_pages) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %s, got %s",
                           rsp_text(want), rsp_text(rsp_data));
            end
         end
      end
   end

   // watchdog on cycles with no transaction in either direction
   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("page_frame_allocator_refcount_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      mismatches = 0;
      stall_cycles = 0;
      gaps_on = 1'b1;
      foreach (frame_refs[i]) frame_refs[i] = '0;
      foreach (frame_link[i]) frame_link[i] = '0;
      list_top = '0;
      list_filled = 1'b0;
      free_count = '0;
      low_page = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_count_limits();
      test_random_traffic();

      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_rsps.size() == 0)
         $display("page_frame_allocator_refcount_tb OK");
      else
         $display("page_frame_allocator_refcount_tb NOT OK");
      $finish;
   end

endmodule

/* files.f */
rtl/pfa_pkg.sv
rtl/pfa_datapath.sv
rtl/pfa_ctrl.sv
rtl/page_frame_allocator_refcount.sv
tb/page_frame_allocator_refcount_tb.sv
